// ----- design/aerp_pkg.sv -----
// Shared types, relocation codes and constants for the ARM ELF relocation patch block.
`timescale 1ns / 1ps
`default_nettype none

package aerp_pkg;

    // ARM ELF relocation type numbers
    localparam logic [7:0] R_NONE       = 8'd0;
    localparam logic [7:0] R_PC24       = 8'd1;
    localparam logic [7:0] R_ABS32      = 8'd2;
    localparam logic [7:0] R_REL32      = 8'd3;
    localparam logic [7:0] R_THM_CALL   = 8'd10;
    localparam logic [7:0] R_GLOB_DAT   = 8'd21;
    localparam logic [7:0] R_JUMP_SLOT  = 8'd22;
    localparam logic [7:0] R_RELATIVE   = 8'd23;
    localparam logic [7:0] R_PLT32      = 8'd27;
    localparam logic [7:0] R_CALL       = 8'd28;
    localparam logic [7:0] R_JUMP24     = 8'd29;
    localparam logic [7:0] R_THM_JUMP24 = 8'd30;
    localparam logic [7:0] R_V4BX       = 8'd40;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_THUMB_BAD = 2'd2;

    // Constant words
    localparam logic [31:0] V4BX_KEEP_MASK = 32'hf000000f;
    localparam logic [31:0] V4BX_SET_BITS  = 32'h01a0f000;
    localparam logic [31:0] THUMB_BIAS     = 32'h00ffffff;
    localparam logic [31:0] THUMB_SPAN     = 32'h01fffffe;
    localparam logic [31:0] WORD_ALL_ONES  = 32'hffffffff;

    // Relocation classes after decode
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_SYM   = 3'd1,
        K_ABS   = 3'd2,
        K_REL   = 3'd3,
        K_ARMBR = 3'd4,
        K_V4BX  = 3'd5,
        K_THUMB = 3'd6
    } kind_t;

    // Second stage contents handed to the result formatter
    typedef struct packed {
        kind_t       kind;
        logic [31:0] stored;
        logic [31:0] sum;
    } fmt_in_t;

    // Formatted result
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  status;
    } fmt_out_t;

endpackage

`default_nettype wire

// ----- design/aerp_in_if.sv -----
// Input channel carrying one relocation per beat.
`timescale 1ns / 1ps
`default_nettype none

interface aerp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  op;
    logic [31:0] place_address;
    logic [31:0] stored_word;
    logic [31:0] symbol_value;

    modport source (output valid, op, place_address, stored_word, symbol_value,
                    input ready);
    modport sink   (input valid, op, place_address, stored_word, symbol_value,
                    output ready);
endinterface

`default_nettype wire

// ----- design/aerp_out_if.sv -----
// Output channel carrying one patched word and status per beat.
`timescale 1ns / 1ps
`default_nettype none

interface aerp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] patched_word;
    logic [1:0]  status;

    modport source (output valid, patched_word, status, input ready);
    modport sink   (input valid, patched_word, status, output ready);
endinterface

`default_nettype wire

// ----- design/arm_elf_relocation_patch_top.sv -----
// Top level of the ARM ELF relocation patch pipeline.
//
// Usage: one relocation enters per beat on the item channel (type, place
// address P, stored word A, symbol value S); one beat leaves on the result
// channel with the patched word and a status (ok, unsupported type, or Thumb
// branch target bad). Beats come out in the order they went in.
// Pipeline: an accepted item passes through the three register stages:
// decode and S - P, the shared 32-bit add, and the result format stage,
// which is also the output register.
// Throughput: one item per cycle; a new item is taken every cycle while the
// result side keeps taking beats.
// Stall: each stage loads when it is empty or the stage after it moves, so a
// stalled receiver fills the pipe up to three items and then item.ready drops;
// nothing is lost or repeated. Bubbles are squeezed out under stall.
// Reset: rst_n clears all stage valid bits; the payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module arm_elf_relocation_patch_top
    import aerp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    aerp_in_if.sink   item,
    aerp_out_if.source result
);

    // Stage valid bits
    logic v1_reg, v2_reg, v3_reg;
    logic ld1, ld2, ld3;

    // Stage 1 payload
    kind_t       kind1_reg, kind1_next;
    logic [31:0] a1_reg;
    logic [31:0] x1_reg, x1_next;
    logic [31:0] y1_reg, y1_next;

    // Stage 2 payload
    fmt_in_t     s2_reg, s2_next;

    // Stage 3 (output) payload
    fmt_out_t    fmt_res;
    fmt_out_t    out_reg;

    logic [31:0] diff;
    logic [31:0] arm_add;
    logic [24:0] thumb_off;
    logic        t_sg;

    // Stage load enables: load when empty or downstream moves
    assign ld3 = !v3_reg || result.ready;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign item.ready = ld1;

    // Stage 1: decode type, S - P, branch offset extraction
    always_comb
    begin
        diff    = item.symbol_value - item.place_address;
        arm_add = {{6{item.stored_word[23]}}, item.stored_word[23:0], 2'b00};
        t_sg    = item.stored_word[10];
        thumb_off = {t_sg,
                     ~(item.stored_word[29] ^ t_sg),
                     ~(item.stored_word[27] ^ t_sg),
                     item.stored_word[9:0],
                     item.stored_word[26:16],
                     1'b0};

        unique case (item.op) inside
            R_GLOB_DAT, R_JUMP_SLOT:            kind1_next = K_SYM;
            R_RELATIVE, R_ABS32:                kind1_next = K_ABS;
            R_REL32:                            kind1_next = K_REL;
            R_PC24, R_PLT32, R_CALL, R_JUMP24:  kind1_next = K_ARMBR;
            R_V4BX:                             kind1_next = K_V4BX;
            R_THM_CALL, R_THM_JUMP24:           kind1_next = K_THUMB;
            default:                            kind1_next = K_NONE;
        endcase

        // Operands for the shared adder
        case (kind1_next)
            K_SYM:
            begin
                x1_next = item.symbol_value;
                y1_next = '0;
            end
            K_ABS:
            begin
                x1_next = item.symbol_value;
                y1_next = item.stored_word;
            end
            K_REL:
            begin
                x1_next = diff;
                y1_next = item.stored_word;
            end
            K_ARMBR:
            begin
                x1_next = diff;
                y1_next = arm_add;
            end
            K_THUMB:
            begin
                x1_next = diff;
                y1_next = {{7{thumb_off[24]}}, thumb_off};
            end
            default:
            begin
                x1_next = '0;
                y1_next = '0;
            end
        endcase
    end

    // Stage 2: shared 32-bit add
    always_comb
    begin
        s2_next.kind   = kind1_reg;
        s2_next.stored = a1_reg;
        s2_next.sum    = x1_reg + y1_reg;
    end

    // Stage 3: format
    aerp_format u_format (
        .fin  (s2_reg),
        .fout (fmt_res)
    );

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= item.valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ld1 && item.valid)
        begin
            kind1_reg <= kind1_next;
            a1_reg    <= item.stored_word;
            x1_reg    <= x1_next;
            y1_reg    <= y1_next;
        end
        if (ld2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (ld3 && v2_reg)
        begin
            out_reg <= fmt_res;
        end
    end

    assign result.valid        = v3_reg;
    assign result.patched_word = out_reg.word;
    assign result.status       = out_reg.status;

    // Checks
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !result.ready && v2_reg && v1_reg) |-> !item.ready)
        else $error("full pipe under stall still accepts");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> v1_reg)
        else $error("accepted item missing in stage 1");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_NONE) |-> (result.patched_word == '0))
        else $error("unsupported type with nonzero word");

    a_bad_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_THUMB_BAD)
            |-> (result.patched_word == WORD_ALL_ONES))
        else $error("bad Thumb target without all-ones word");

endmodule

`default_nettype wire

// ----- design/aerp_format.sv -----
// Result formatter: per-class result select; re-encodes branch offsets, with a range check for Thumb.
`timescale 1ns / 1ps
`default_nettype none

module aerp_format
    import aerp_pkg::*;
(
    input  fmt_in_t  fin,
    output fmt_out_t fout
);

    logic [31:0] biased;
    logic        thumb_ok;
    logic        sg;
    logic        j1;
    logic        j2;
    logic [15:0] h0;
    logic [15:0] h1;

    // Thumb: odd target with signed value strictly inside +/- 2^24
    always_comb
    begin
        biased   = fin.sum + THUMB_BIAS;
        thumb_ok = fin.sum[0] && (biased <= THUMB_SPAN);
        sg       = fin.sum[24];
        j1       = sg ^ ~fin.sum[23];
        j2       = sg ^ ~fin.sum[22];
        h0       = {fin.stored[15:11], sg, fin.sum[21:12]};
        h1       = {fin.stored[31:30], j1, fin.stored[28], j2, fin.sum[11:1]};
    end

    // Per-class result select
    always_comb
    begin
        fout.word   = '0;
        fout.status = ST_OK;
        case (fin.kind)
            K_SYM, K_ABS, K_REL:
            begin
                fout.word = fin.sum;
            end
            K_ARMBR:
            begin
                fout.word = {fin.stored[31:24], fin.sum[25:2]};
            end
            K_V4BX:
            begin
                fout.word = (fin.stored & V4BX_KEEP_MASK) | V4BX_SET_BITS;
            end
            K_THUMB:
            begin
                if (thumb_ok)
                begin
                    fout.word = {h1, h0};
                end
                else
                begin
                    fout.word   = WORD_ALL_ONES;
                    fout.status = ST_THUMB_BAD;
                end
            end
            default:
            begin
                fout.word   = '0;
                fout.status = ST_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire
